/* rtl/sfdd_pkg.sv */
// ----------------------------------------------------------------------------
// sfdd_pkg: shared types and constants of the frame difference detector
// Holds field widths, Rec.709 weights in Q16, register map codes, payload
// structs and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfdd_pkg;

   // Default limits for the top-level parameters.
   localparam int unsigned DEF_MAX_WIDTH  = 4096;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;
   localparam int unsigned DEF_MAX_STEP   = 128;

   // Field and register widths.
   localparam int SIZE_W     = 13;
   localparam int STEP_W     = 8;
   localparam int LIMIT_W    = 16;
   localparam int COMP_W     = 16;
   localparam int MEAN_W     = 16;
   localparam int DEC_W      = 2;
   localparam int COUNT_W    = 25;
   localparam int SUM_W      = 41;
   localparam int NUM_W      = SUM_W + 1;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = PROD_W + 2;
   localparam int DIFF_W     = 17;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Rec.709 luma weights in Q16; they add up to 1.0.
   localparam logic [COMP_W-1:0] WEIGHT_RED   = 16'd13933;
   localparam logic [COMP_W-1:0] WEIGHT_GREEN = 16'd46871;
   localparam logic [COMP_W-1:0] WEIGHT_BLUE  = 16'd4732;
   localparam logic [DIFF_W-1:0] ONE_Q16      = 17'h10000;
   localparam logic [ACC_W-1:0]  ROUND_Q16    = 34'd32768;
   localparam logic [MEAN_W-1:0] MEAN_MAX     = 16'hFFFF;

   // Register reset values.
   localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH     = 13'd1920;
   localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT    = 13'd1080;
   localparam logic [STEP_W-1:0]  RST_GRID_PITCH      = 8'd16;
   localparam logic [LIMIT_W-1:0] RST_DUPLICATE_LIMIT = 16'd98;
   localparam logic [LIMIT_W-1:0] RST_SCENE_LIMIT     = 16'd14418;

   // Register map, indexed by word address.
   typedef enum logic [2:0] {
      REG_FRAME_WIDTH     = 3'd0,
      REG_FRAME_HEIGHT    = 3'd1,
      REG_GRID_PITCH      = 3'd2,
      REG_DUPLICATE_LIMIT = 3'd3,
      REG_SCENE_LIMIT     = 3'd4
   } reg_index_type;

   // Frame decision codes.
   typedef enum logic [DEC_W-1:0] {
      DEC_INTERPOLATE = 2'd0,
      DEC_DUPLICATE   = 2'd1,
      DEC_SCENE_CUT   = 2'd2
   } decision_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  frame_width;
      logic [SIZE_W-1:0]  frame_height;
      logic [STEP_W-1:0]  grid_pitch;
      logic [LIMIT_W-1:0] duplicate_limit;
      logic [LIMIT_W-1:0] scene_limit;
   } cfg_type;

   typedef struct packed {
      logic [COMP_W-1:0] first_red;
      logic [COMP_W-1:0] first_green;
      logic [COMP_W-1:0] first_blue;
      logic [COMP_W-1:0] second_red;
      logic [COMP_W-1:0] second_green;
      logic [COMP_W-1:0] second_blue;
   } req_payload_type;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean_difference;
      decision_type       decision;
      logic [COUNT_W-1:0] sample_total;
   } rsp_payload_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic snap;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic end_frame;
      logic pipe_busy;
      logic div_busy;
      logic div_done;
   } dp_status_type;

endpackage

/* rtl/sfdd_csr.sv */
// ----------------------------------------------------------------------------
// sfdd_csr: configuration register file
// APB-style slave holding frame size, sample step and the two decision
// limits. Writes complete in the access phase; reads return the register.
// ----------------------------------------------------------------------------
module sfdd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfdd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfdd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfdd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output sfdd_pkg::cfg_type                 cfg
);
   import sfdd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          write_en;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   // Register write decode; addresses past the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_FRAME_WIDTH:     cfg_in.frame_width     = csr_pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT:    cfg_in.frame_height    = csr_pwdata[SIZE_W-1:0];
            REG_GRID_PITCH:      cfg_in.grid_pitch      = csr_pwdata[STEP_W-1:0];
            REG_DUPLICATE_LIMIT: cfg_in.duplicate_limit = csr_pwdata[LIMIT_W-1:0];
            REG_SCENE_LIMIT:     cfg_in.scene_limit     = csr_pwdata[LIMIT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= RST_FRAME_WIDTH;
         cfg_ff.frame_height    <= RST_FRAME_HEIGHT;
         cfg_ff.grid_pitch      <= RST_GRID_PITCH;
         cfg_ff.duplicate_limit <= RST_DUPLICATE_LIMIT;
         cfg_ff.scene_limit     <= RST_SCENE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (index)
         REG_FRAME_WIDTH:     csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_GRID_PITCH:      csr_prdata = CSR_DATA_W'(cfg_ff.grid_pitch);
         REG_DUPLICATE_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.duplicate_limit);
         REG_SCENE_LIMIT:     csr_prdata = CSR_DATA_W'(cfg_ff.scene_limit);
         default:             csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/sfdd_div.sv */
// ----------------------------------------------------------------------------
// sfdd_div: restoring divider for the frame mean
// Produces one quotient bit per cycle, most significant first, with a
// remainder as wide as the divisor. The quotient holds after completion.
// ----------------------------------------------------------------------------
module sfdd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sfdd_pkg::NUM_W-1:0]     numerator,
   input  logic [sfdd_pkg::COUNT_W-1:0]   divisor,
   output logic                           busy,
   output logic                           done,
   output logic [sfdd_pkg::NUM_W-1:0]     quotient
);
   import sfdd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0]   quot_ff, quot_in;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   trial_diff;
   logic               last_step;

   assign trial      = {rem_ff, quot_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign last_step  = (count_ff == CNT_W'(NUM_W - 1));

   // One shift-and-subtract step per cycle; the numerator shifts out of the
   // quotient register as the quotient bits shift in.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         den_in   = divisor;
         quot_in  = numerator;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial_diff[COUNT_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[COUNT_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign done     = busy_ff && last_step;
   assign quotient = quot_ff;

endmodule

/* rtl/sfdd_dp.sv */
// ----------------------------------------------------------------------------
// sfdd_dp: datapath of the frame difference detector
// Tracks the raster position and sample phase, runs the weighted absolute
// difference pipeline, accumulates sum and count, and forms the result.
// ----------------------------------------------------------------------------
module sfdd_dp #(
   parameter int unsigned MAX_WIDTH  = sfdd_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sfdd_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned MAX_STEP   = sfdd_pkg::DEF_MAX_STEP
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sfdd_pkg::cfg_type           cfg,
   input  sfdd_pkg::req_payload_type   req_payload,
   input  sfdd_pkg::dp_cmd_type        cmd,
   output sfdd_pkg::dp_status_type     status,
   output sfdd_pkg::rsp_payload_type   rsp_payload
);
   import sfdd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PH_W  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
      int unsigned r;
      if (v == 0) begin
         r = 1;
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COMP_W-1:0] abs_diff(logic [COMP_W-1:0] a,
                                                  logic [COMP_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Raster position and sample phase.
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic [PH_W-1:0]  col_ph_ff, col_ph_in;
   logic [PH_W-1:0]  row_ph_ff, row_ph_in;

   logic [COL_W:0]   width_eff, col_inc;
   logic [ROW_W:0]   height_eff, row_inc;
   logic [PH_W:0]    step_eff, col_ph_inc, row_ph_inc;
   logic [PH_W-1:0]  half;
   logic [PH_W-1:0]  col_ph_next, row_ph_next;
   logic             sampled, end_line, end_frame;

   assign width_eff  = (COL_W+1)'(clamp_size(32'(cfg.frame_width), MAX_WIDTH));
   assign height_eff = (ROW_W+1)'(clamp_size(32'(cfg.frame_height), MAX_HEIGHT));
   assign step_eff   = (PH_W+1)'(clamp_size(32'(cfg.grid_pitch), MAX_STEP));
   assign half       = step_eff[PH_W:1];

   assign col_inc    = (COL_W+1)'(col_pos_ff) + (COL_W+1)'(1);
   assign row_inc    = (ROW_W+1)'(row_pos_ff) + (ROW_W+1)'(1);
   assign col_ph_inc = (PH_W+1)'(col_ph_ff) + (PH_W+1)'(1);
   assign row_ph_inc = (PH_W+1)'(row_ph_ff) + (PH_W+1)'(1);

   // A phase at or past the step wraps to zero.
   assign col_ph_next = (col_ph_inc >= step_eff) ? '0 : col_ph_inc[PH_W-1:0];
   assign row_ph_next = (row_ph_inc >= step_eff) ? '0 : row_ph_inc[PH_W-1:0];

   assign sampled   = (col_ph_ff == half) && (row_ph_ff == half);
   assign end_line  = (col_inc >= width_eff);
   assign end_frame = end_line && (row_inc >= height_eff);

   // Position update on each transfer.
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      col_ph_in  = col_ph_ff;
      row_ph_in  = row_ph_ff;
      if (cmd.accept) begin
         if (end_frame) begin
            col_pos_in = '0;
            row_pos_in = '0;
            col_ph_in  = '0;
            row_ph_in  = '0;
         end else if (end_line) begin
            col_pos_in = '0;
            col_ph_in  = '0;
            row_pos_in = row_inc[ROW_W-1:0];
            row_ph_in  = row_ph_next;
         end else begin
            col_pos_in = col_inc[COL_W-1:0];
            col_ph_in  = col_ph_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         col_ph_ff  <= '0;
         row_ph_ff  <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         col_ph_ff  <= col_ph_in;
         row_ph_ff  <= row_ph_in;
      end
   end

   // Difference pipeline: absolute differences, weighted products,
   // rounded and clamped sum, then accumulation.
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [COMP_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [PROD_W-1:0] s2_red_ff, s2_green_ff, s2_blue_ff;
   logic [DIFF_W-1:0] s3_diff_ff, s3_diff_in;
   logic [ACC_W-1:0]  weighted;
   logic [ACC_W-1:0]  rounded;

   assign weighted = ACC_W'(s2_red_ff) + ACC_W'(s2_green_ff) + ACC_W'(s2_blue_ff)
                   + ROUND_Q16;
   assign rounded  = weighted >> 16;
   assign s3_diff_in = (rounded > ACC_W'(ONE_Q16)) ? ONE_Q16 : rounded[DIFF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept && sampled;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_red_ff   <= abs_diff(req_payload.first_red, req_payload.second_red);
      s1_green_ff <= abs_diff(req_payload.first_green, req_payload.second_green);
      s1_blue_ff  <= abs_diff(req_payload.first_blue, req_payload.second_blue);
      s2_red_ff   <= PROD_W'(s1_red_ff) * PROD_W'(WEIGHT_RED);
      s2_green_ff <= PROD_W'(s1_green_ff) * PROD_W'(WEIGHT_GREEN);
      s2_blue_ff  <= PROD_W'(s1_blue_ff) * PROD_W'(WEIGHT_BLUE);
      s3_diff_ff  <= s3_diff_in;
   end

   // Frame accumulators; cleared when the frame totals move to the divider.
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   always_comb begin
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      if (cmd.snap) begin
         sum_in   = '0;
         cnt_in   = '0;
         total_in = cnt_ff;
      end else if (s3_valid_ff) begin
         sum_in = sum_ff + SUM_W'(s3_diff_ff);
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // Mean with round to nearest: (sum + count/2) / count.
   logic [NUM_W-1:0] numerator;
   logic [NUM_W-1:0] quotient;
   logic             div_busy, div_done;

   assign numerator = NUM_W'(sum_ff) + NUM_W'(cnt_ff >> 1);

   sfdd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.snap),
      .numerator (numerator),
      .divisor   (cnt_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quotient)
   );

   // Result formation: saturate the mean, then classify it.
   rsp_payload_type rsp_ff, rsp_in;
   logic [MEAN_W-1:0] mean_sat;

   assign mean_sat = (|quotient[NUM_W-1:MEAN_W]) ? MEAN_MAX : quotient[MEAN_W-1:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.sample_total = total_ff;
         if (total_ff == '0) begin
            rsp_in.mean_difference = MEAN_MAX;
            rsp_in.decision        = DEC_SCENE_CUT;
         end else begin
            rsp_in.mean_difference = mean_sat;
            if (mean_sat <= cfg.duplicate_limit) begin
               rsp_in.decision = DEC_DUPLICATE;
            end else if (mean_sat >= cfg.scene_limit) begin
               rsp_in.decision = DEC_SCENE_CUT;
            end else begin
               rsp_in.decision = DEC_INTERPOLATE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload      = rsp_ff;
   assign status.end_frame = end_frame;
   assign status.pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign status.div_busy  = div_busy;
   assign status.div_done  = div_done;

endmodule

/* rtl/sfdd_ctrl.sv */
// ----------------------------------------------------------------------------
// sfdd_ctrl: controller of the frame difference detector
// Accepts pixels while running, drains the difference pipeline after the
// last pixel of a frame, sequences the divider and hands off the result.
// ----------------------------------------------------------------------------
module sfdd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  sfdd_pkg::dp_status_type   status,
   output sfdd_pkg::dp_cmd_type      cmd
);
   import sfdd_pkg::*;

   typedef enum logic [3:0] {
      ST_RUN     = 4'b0001,
      ST_DRAIN   = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_DELIVER = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_RUN: begin
            cmd.accept = req_valid;
            if (req_valid && status.end_frame) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.snap = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // The output register is free once its last transfer completes.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_RUN);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // The last pixel of a frame closes the input until the result is formed.
   a_stall_after_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.end_frame |=> req_stall)
      else $error("input not stalled after end of frame");

   // Pixels are never taken while a division is running.
   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !status.div_busy)
      else $error("pixel accepted while divider busy");

   // The divider starts on the cycle after the frame totals are captured.
   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |=> status.div_busy)
      else $error("divider did not start");

   // A new result appears only out of the delivery state.
   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("result raised outside delivery");
`endif

endmodule

/* rtl/sampled_frame_difference_detector.sv */
// ----------------------------------------------------------------------------
// sampled_frame_difference_detector: subsampled frame difference detector
// Compares co-located pixels of two frames on a sample grid and reports the
// mean weighted difference with an interpolate, duplicate or cut decision.
//
//   Port group   Direction   Handshake         Transfer
//   req_*        in          valid / stall     one pixel pair per transfer
//   rsp_*        out         valid / stall     one result per frame
//   csr_*        in / out    APB-style         one register write or read
//
// Within a frame one pixel is taken every clock cycle.
// After the last pixel the input stalls while the difference pipeline drains,
// the restoring divider forms the mean one quotient bit per cycle and the
// result register is loaded.
// The input also stays stalled while a previous result waits to be taken.
// Reset clears the raster position, accumulators and result valid, and
// returns the registers to their defaults.
// ----------------------------------------------------------------------------
module sampled_frame_difference_detector #(
   parameter int unsigned MAX_WIDTH  = sfdd_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sfdd_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned MAX_STEP   = sfdd_pkg::DEF_MAX_STEP
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sfdd_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sfdd_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfdd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfdd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfdd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sfdd_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   sfdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencing of pixel intake, end-of-frame division and result handoff.
   sfdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Position tracking, difference pipeline, accumulation and division.
   sfdd_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_STEP   (MAX_STEP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/sampled_frame_difference_detector_tb.sv */
// ----------------------------------------------------------------------------
// sampled_frame_difference_detector_tb: self-checking frame difference bench
// Streams pixel pairs through the detector in whole frames under several
// register settings, predicts each end-of-frame result with a cycle-free
// model of the sampling grid and the mean, and compares every result field.
// Both channels idle and stall in random bursts, and registers are read back.
// ----------------------------------------------------------------------------
module sampled_frame_difference_detector_tb;
   import sfdd_pkg::*;

   localparam int unsigned FRAME_MAX     = 4096;
   localparam int unsigned STEP_MAX      = 128;
   localparam int unsigned RED_WEIGHT    = 13933;
   localparam int unsigned GREEN_WEIGHT  = 46871;
   localparam int unsigned BLUE_WEIGHT   = 4732;
   localparam longint unsigned UNITY_Q16 = 64'd65536;
   localparam longint unsigned SUM_MASK  = 64'h1FF_FFFF_FFFF;
   localparam int unsigned COUNT_MASK    = 32'h1FF_FFFF;
   localparam int unsigned POSITION_MASK = 32'hFFF;
   localparam int unsigned DRAIN_CYCLES  = 64;
   localparam int unsigned PHASE_PIXELS  = 45;
   localparam int unsigned MAX_BURST     = 17;
   localparam logic [2:0] UNMAPPED_FIRST = 3'd5;
   localparam logic [2:0] UNMAPPED_LAST  = 3'd7;

   typedef enum {MOTION_NONE, MOTION_SMALL, MOTION_RANDOM, MOTION_FULL} motion_type;

   // Tracks the raster walk and the running sums, and keeps the results of
   // completed frames until the block delivers them.
   class frame_scoreboard;
      int unsigned reg_file [5];
      int unsigned col_pos, row_pos, col_phase, row_phase;
      longint unsigned diff_sum;
      int unsigned sample_count;
      rsp_payload_type frame_results [$];
      int unsigned errors;

      function new();
         errors = 0;
         reg_file[REG_FRAME_WIDTH]     = 1920;
         reg_file[REG_FRAME_HEIGHT]    = 1080;
         reg_file[REG_GRID_PITCH]      = 16;
         reg_file[REG_DUPLICATE_LIMIT] = 98;
         reg_file[REG_SCENE_LIMIT]     = 14418;
         start_frame();
      endfunction

      function void start_frame();
         col_pos = 0;
         row_pos = 0;
         col_phase = 0;
         row_phase = 0;
         diff_sum = 0;
         sample_count = 0;
      endfunction

      // A zero size acts as one; anything past the maximum saturates.
      function int unsigned size_clamp(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         return (v > maxv) ? maxv : v;
      endfunction

      function int unsigned channel_gap(logic [15:0] a, logic [15:0] b);
         return (a > b) ? int'(a - b) : int'(b - a);
      endfunction

      function int unsigned advance_phase(int unsigned ph, int unsigned s);
         return (ph + 1 >= s) ? 0 : ph + 1;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_FRAME_WIDTH:     reg_file[REG_FRAME_WIDTH]     = 32'(value[SIZE_W-1:0]);
            REG_FRAME_HEIGHT:    reg_file[REG_FRAME_HEIGHT]    = 32'(value[SIZE_W-1:0]);
            REG_GRID_PITCH:      reg_file[REG_GRID_PITCH]      = 32'(value[STEP_W-1:0]);
            REG_DUPLICATE_LIMIT: reg_file[REG_DUPLICATE_LIMIT] = 32'(value[LIMIT_W-1:0]);
            REG_SCENE_LIMIT:     reg_file[REG_SCENE_LIMIT]     = 32'(value[LIMIT_W-1:0]);
            default: ;
         endcase
      endfunction

      function int unsigned frame_pixels();
         return size_clamp(reg_file[REG_FRAME_WIDTH], FRAME_MAX) *
                size_clamp(reg_file[REG_FRAME_HEIGHT], FRAME_MAX);
      endfunction

      function int unsigned pending();
         return frame_results.size();
      endfunction

      // Advances the model by one accepted pixel pair.
      function void note_pixel(req_payload_type p);
         int unsigned w, h, s, half, mean;
         longint unsigned weighted, d, m;
         bit line_end;
         rsp_payload_type e;
         w = size_clamp(reg_file[REG_FRAME_WIDTH], FRAME_MAX);
         h = size_clamp(reg_file[REG_FRAME_HEIGHT], FRAME_MAX);
         s = size_clamp(reg_file[REG_GRID_PITCH], STEP_MAX);
         half = s / 2;
         e = '0;

         // Only the pixel half a step into each grid cell is sampled.
         if (col_phase == half && row_phase == half) begin
            weighted = 64'(channel_gap(p.first_red, p.second_red)) * RED_WEIGHT
                     + 64'(channel_gap(p.first_green, p.second_green)) * GREEN_WEIGHT
                     + 64'(channel_gap(p.first_blue, p.second_blue)) * BLUE_WEIGHT;
            d = (weighted + 64'd32768) >> 16;
            if (d > UNITY_Q16) d = UNITY_Q16;
            diff_sum = (diff_sum + d) & SUM_MASK;
            sample_count = (sample_count + 1) & COUNT_MASK;
         end

         line_end = (col_pos + 1 >= w);
         if (line_end && row_pos + 1 >= h) begin
            // Last pixel of the frame: mean, decision and sample count.
            if (sample_count == 0) begin
               e.mean_difference = 16'hFFFF;
               e.decision = DEC_SCENE_CUT;
            end else begin
               m = (diff_sum + 64'(sample_count / 2)) / 64'(sample_count);
               mean = (m > 64'd65535) ? 32'd65535 : 32'(m);
               e.mean_difference = mean[15:0];
               if (mean <= reg_file[REG_DUPLICATE_LIMIT]) e.decision = DEC_DUPLICATE;
               else if (mean >= reg_file[REG_SCENE_LIMIT]) e.decision = DEC_SCENE_CUT;
               else e.decision = DEC_INTERPOLATE;
            end
            e.sample_total = sample_count[COUNT_W-1:0];
            frame_results.push_back(e);
            start_frame();
         end else if (line_end) begin
            col_pos = 0;
            col_phase = 0;
            row_pos = (row_pos + 1) & POSITION_MASK;
            row_phase = advance_phase(row_phase, s);
         end else begin
            col_pos = (col_pos + 1) & POSITION_MASK;
            col_phase = advance_phase(col_phase, s);
         end
      endfunction

      // Compares one delivered result with the oldest waiting one.
      function void check_result(rsp_payload_type r);
         rsp_payload_type e;
         if (frame_results.size() == 0) begin
            $display("%0t: result with none expected: mean %0d decision %0d samples %0d",
                     $time, r.mean_difference, r.decision, r.sample_total);
            errors++;
            return;
         end
         e = frame_results.pop_front();
         if (r.mean_difference !== e.mean_difference) begin
            $display("%0t: mean_difference expected %0d actual %0d",
                     $time, e.mean_difference, r.mean_difference);
            errors++;
         end
         if (r.decision !== e.decision) begin
            $display("%0t: decision expected %0d actual %0d", $time, e.decision, r.decision);
            errors++;
         end
         if (r.sample_total !== e.sample_total) begin
            $display("%0t: sample_total expected %0d actual %0d",
                     $time, e.sample_total, r.sample_total);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   frame_scoreboard board = new();
   bit gaps_on = 1'b1;

   sampled_frame_difference_detector uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run ends here if the block stops delivering.
   initial begin
      #25_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: checks each transfer and stalls in random bursts.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_payload);
         if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, MAX_BURST);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Offers one pixel pair and holds it until the transfer completes.
   task automatic send_pixel(input req_payload_type pixel);
      req_valid <= 1'b1;
      req_payload <= pixel;
      do @(posedge clock); while (req_stall);
      board.note_pixel(pixel);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
      end
   endtask

   function automatic req_payload_type pixel_pair(input logic [15:0] r0, g0, b0, r1, g1, b1);
      return {r0, g0, b0, r1, g1, b1};
   endfunction

   // Builds a pair whose difference follows the requested kind of motion.
   function automatic req_payload_type make_pixel(input motion_type motion);
      logic [15:0] r0, g0, b0;
      r0 = 16'($urandom);
      g0 = 16'($urandom);
      b0 = 16'($urandom);
      case (motion)
         MOTION_NONE: return pixel_pair(r0, g0, b0, r0, g0, b0);
         MOTION_SMALL:
            return pixel_pair(r0, g0, b0, r0 ^ 16'($urandom_range(0, 1023)),
                              g0 ^ 16'($urandom_range(0, 1023)),
                              b0 ^ 16'($urandom_range(0, 1023)));
         MOTION_FULL:
            if ($urandom_range(0, 1) == 0)
               return pixel_pair(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
               return pixel_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
         default:
            return pixel_pair(r0, g0, b0, 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
   endfunction

   task automatic send_frame(input motion_type motion);
      repeat (board.frame_pixels()) send_pixel(make_pixel(motion));
   endtask

   // Stops the sender until every frame result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register transfer: setup phase, access phase, then the bus returns to idle.
   task automatic csr_transfer(input bit is_write, input logic [2:0] index,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register and reads mapped ones back.
   task automatic set_register(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] readback;
      csr_transfer(1'b1, index, value, readback);
      board.write_reg(index, value);
      if (index <= REG_SCENE_LIMIT) begin
         csr_transfer(1'b0, index, '0, readback);
         if (readback !== board.reg_file[index]) begin
            $display("%0t: register %0d read expected %0d actual %0d",
                     $time, index, board.reg_file[index], readback);
            board.errors++;
         end
      end
   endtask

   task automatic configure(input int unsigned w, h, s, dup, scene);
      set_register(REG_FRAME_WIDTH, w);
      set_register(REG_FRAME_HEIGHT, h);
      set_register(REG_GRID_PITCH, s);
      set_register(REG_DUPLICATE_LIMIT, dup);
      set_register(REG_SCENE_LIMIT, scene);
   endtask

   initial begin
      int unsigned sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every pixel sampled: a still frame, a full-scale frame, then one
      // channel at a time in both directions for a mid-range mean.
      configure(3, 2, 1, 98, 14418);
      send_frame(MOTION_NONE);
      send_frame(MOTION_FULL);
      send_pixel(pixel_pair(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(pixel_pair(16'h0000, 16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(pixel_pair(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(pixel_pair(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
      send_pixel(pixel_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h0000));
      send_pixel(pixel_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
      wait_for_results();

      // Zero sizes and step act as one; equal limits let the duplicate test win.
      configure(0, 0, 0, 0, 0);
      send_pixel(make_pixel(MOTION_NONE));
      send_pixel(make_pixel(MOTION_FULL));
      wait_for_results();
      set_register(REG_SCENE_LIMIT, 65535);
      send_pixel(make_pixel(MOTION_FULL));
      send_pixel(pixel_pair(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      wait_for_results();

      // A step past the maximum on a tiny frame leaves no samples at all.
      configure(2, 2, 255, 98, 14418);
      send_frame(MOTION_RANDOM);
      wait_for_results();

      // Writes to unmapped addresses must leave the settings alone.
      for (int i = UNMAPPED_FIRST; i <= UNMAPPED_LAST; i++) set_register(3'(i), $urandom);
      send_frame(MOTION_SMALL);
      wait_for_results();

      // Random small geometries with mixed motion per frame.
      repeat (8) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         configure($urandom_range(0, 9), $urandom_range(0, 6),
                   ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 255),
                   $urandom_range(0, 1500), $urandom_range(0, 40000));
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            sent += board.frame_pixels();
            send_frame(motion_type'($urandom_range(0, 3)));
         end
         wait_for_results();
      end

      // Closing stretch at full rate on both sides.
      gaps_on = 1'b0;
      configure(4, 3, 2, 300, 20000);
      sent = 0;
      while (sent < PHASE_PIXELS) begin
         sent += board.frame_pixels();
         send_frame(motion_type'($urandom_range(0, 3)));
      end
      wait_for_results();

      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
